FILE: design/mhtq_pkg.sv
// Shared types, constants and helpers for the min-heap timer queue.
package mhtq_pkg;

	localparam int CAPACITY = 32;
	localparam int ID_BITS  = 8;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IW     = ADDR_W + 2;

	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 80;
	localparam int OUT_USER_W = 3;

	typedef logic [ID_BITS-1:0] id_t;

	typedef struct packed {
		logic [31:0] expire;
		id_t         id;
		logic        active;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_POP    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		K_ADDED       = 3'd0,
		K_FULL        = 3'd1,
		K_CANCEL_DONE = 3'd2,
		K_POPPED      = 3'd3,
		K_POP_EMPTY   = 3'd4,
		K_FIRED       = 3'd5,
		K_TICK_DONE   = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_CHK,
		ST_ADD_CMP,
		ST_CAN_RD,
		ST_CAN_CMP,
		ST_TICK_CHK,
		ST_REM_START,
		ST_REM_HELD,
		ST_SINK_CHK,
		ST_SINK_L,
		ST_SINK_R,
		ST_SINK_DEC,
		ST_REM_END,
		ST_OUT
	} state_t;

	// Keep the low ID_BITS bits of the 8-bit input id, zero-extend if wider.
	function automatic id_t id_from_in(input logic [7:0] v);
		logic [ID_BITS+7:0] w;
		w = {{ID_BITS{1'b0}}, v};
		return w[ID_BITS-1:0];
	endfunction

	function automatic logic [7:0] id_to_out(input id_t v);
		logic [ID_BITS+7:0] w;
		w = {8'd0, v};
		return w[7:0];
	endfunction

endpackage

FILE: design/mhtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/min_heap_timer_queue_core.sv
// Top level of the min-heap timer queue: sequencer, shared comparator, heap RAM.
//
// Usage:
//   Commands come in on the s_axis group: tuser carries the command (add, cancel,
//   tick, pop), tdata carries timer id, delay and now. Results leave on the
//   m_axis group, one transfer per result; tlast marks the final result of a
//   command. A tick gives one fired result per expired active timer, then a
//   tick-done result with tlast set. Every other command gives one result.
//   The heap lives in a single-port-read RAM; entry 0 is mirrored in a register
//   so the top expiry is always at hand. One comparator serves add, tick and sink.
//   Steps per command (s_axis_tready low meanwhile):
//     add    : one parent read and compare per level climbed, then the entry write
//     cancel : one read and id compare per pending entry
//     pop    : last entry takes the root and sinks; no sink if it empties the heap
//     tick   : per expired entry one check and one pop-like removal, and a result
//              when it fires; then a last check and the tick-done result
//   s_axis_tready returns once the last result is in the output register.
//   A stalled receiver holds the output register; the sequencer waits before
//   loading the next result, so nothing is dropped.
//   Reset empties the heap (count to zero) and clears the output valid; the RAM
//   contents are not cleared, as entries beyond the count are never read.
module min_heap_timer_queue_core
	import mhtq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata, lowest bit up: timer_id[7:0], delay[31:0], now[31:0]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: cmd[1:0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata, lowest bit up: result_id[7:0], result_expire[31:0],
	// pending_count[5:0], top_expire[31:0], heap_empty, one zero pad bit
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// tuser: kind[2:0]
	output logic [OUT_USER_W-1:0] m_axis_tuser,
	output logic                  m_axis_tlast
);

	state_t state_q, state_d;

	// Control state
	logic [CNT_W-1:0] count_q;
	logic             m_valid_q;

	// Command and working registers
	cmd_t              cmd_q;
	id_t               id_q;
	logic [31:0]       exp_q;
	logic [31:0]       now_q;
	logic [ADDR_W-1:0] hole_q;
	logic [ADDR_W-1:0] child_q;
	logic [ADDR_W-1:0] sel_addr_q;
	slot_t             sel_q;
	slot_t             held_q;
	slot_t             top_q;
	logic              fire_q;

	// Pending result
	kind_t       res_kind_q;
	logic [7:0]  res_id_q;
	logic [31:0] res_exp_q;
	logic        res_last_q;

	// Output register
	logic [7:0]        m_id_q;
	logic [31:0]       m_exp_q;
	logic [5:0]        m_cnt_q;
	logic [31:0]       m_top_q;
	logic              m_empty_q;
	kind_t             m_kind_q;
	logic              m_last_q;

	// RAM port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	slot_t             ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	slot_t             ram_rdata;

	// Shared comparator
	logic [31:0] cmp_a;
	logic [31:0] cmp_b;
	logic        cmp_lt;

	logic              s_fire;
	logic              load_out;
	logic [32:0]       sum;
	logic [31:0]       in_exp;
	cmd_t              in_cmd;
	id_t               in_id;
	logic [IW-1:0]     child_w;
	logic              child_in;
	logic [IW-1:0]     right_w;
	logic              right_in;
	logic [ADDR_W-1:0] parent;
	logic              can_last;
	logic              full;

	mhtq_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(CAPACITY)
	) u_heap_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign load_out      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	assign in_cmd = cmd_t'(s_axis_tuser[1:0]);
	assign in_id  = id_from_in(s_axis_tdata[7:0]);
	// Saturate now + delay at the all-ones expiry
	assign sum    = {1'b0, s_axis_tdata[71:40]} + {1'b0, s_axis_tdata[39:8]};
	assign in_exp = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	assign full   = (count_q == CNT_W'(CAPACITY));

	assign cmp_lt   = cmp_a < cmp_b;
	assign child_w  = IW'({hole_q, 1'b1});
	assign child_in = child_w < IW'(count_q);
	assign right_w  = IW'(child_q) + IW'(1);
	assign right_in = right_w < IW'(count_q);
	assign parent   = ADDR_W'((hole_q - 1'b1) >> 1);
	assign can_last = (IW'(hole_q) + IW'(1)) == IW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM control and comparator operands
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = hole_q;
		ram_wdata = held_q;
		ram_re    = 1'b0;
		ram_raddr = hole_q;
		cmp_a     = sel_q.expire;
		cmp_b     = held_q.expire;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					case (in_cmd)
						CMD_ADD:    state_d = full ? ST_OUT : ST_ADD_CHK;
						CMD_CANCEL: state_d = (count_q == '0) ? ST_OUT : ST_CAN_RD;
						CMD_POP:    state_d = (count_q == '0) ? ST_OUT : ST_REM_START;
						CMD_TICK:   state_d = ST_TICK_CHK;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_CHK: begin
				if (hole_q == '0) begin
					ram_we    = 1'b1;
					ram_wdata = slot_t'{expire: exp_q, id: id_q, active: 1'b1};
					state_d   = ST_OUT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = parent;
					state_d   = ST_ADD_CMP;
				end
			end
			ST_ADD_CMP: begin
				// Stop climbing once the parent is not after the new expiry
				cmp_a  = exp_q;
				cmp_b  = ram_rdata.expire;
				ram_we = 1'b1;
				if (!cmp_lt) begin
					ram_wdata = slot_t'{expire: exp_q, id: id_q, active: 1'b1};
					state_d   = ST_OUT;
				end else begin
					ram_wdata = ram_rdata;
					state_d   = ST_ADD_CHK;
				end
			end
			ST_CAN_RD: begin
				ram_re  = 1'b1;
				state_d = ST_CAN_CMP;
			end
			ST_CAN_CMP: begin
				ram_we    = (ram_rdata.id == id_q);
				ram_wdata = slot_t'{expire: ram_rdata.expire, id: ram_rdata.id,
					active: 1'b0};
				state_d   = can_last ? ST_OUT : ST_CAN_RD;
			end
			ST_TICK_CHK: begin
				cmp_a = now_q;
				cmp_b = top_q.expire;
				if (count_q == '0 || cmp_lt) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_REM_START;
				end
			end
			ST_REM_START: begin
				if (count_q == CNT_W'(1)) begin
					state_d = ST_REM_END;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(count_q - 1'b1);
					state_d   = ST_REM_HELD;
				end
			end
			ST_REM_HELD: begin
				state_d = ST_SINK_CHK;
			end
			ST_SINK_CHK: begin
				if (!child_in) begin
					ram_we  = 1'b1;
					state_d = ST_REM_END;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(child_w);
					state_d   = ST_SINK_L;
				end
			end
			ST_SINK_L: begin
				if (right_in) begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(right_w);
					state_d   = ST_SINK_R;
				end else begin
					state_d = ST_SINK_DEC;
				end
			end
			ST_SINK_R: begin
				// Right child wins only when strictly earlier than the left
				cmp_a   = ram_rdata.expire;
				cmp_b   = sel_q.expire;
				state_d = ST_SINK_DEC;
			end
			ST_SINK_DEC: begin
				ram_we = 1'b1;
				if (cmp_lt) begin
					ram_wdata = sel_q;
					state_d   = ST_SINK_CHK;
				end else begin
					state_d = ST_REM_END;
				end
			end
			ST_REM_END: begin
				if (cmd_q == CMD_POP || fire_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_TICK_CHK;
				end
			end
			ST_OUT: begin
				if (load_out) begin
					state_d = res_last_q ? ST_IDLE : ST_TICK_CHK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Heap count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_fire && in_cmd == CMD_ADD && !full) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == ST_REM_START) begin
				count_q <= count_q - 1'b1;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result staging
	always_ff @(posedge clk) begin
		// Mirror heap entry 0 so the top is visible without a RAM read
		if (ram_we && ram_waddr == '0) begin
			top_q <= ram_wdata;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					cmd_q      <= in_cmd;
					id_q       <= in_id;
					exp_q      <= in_exp;
					now_q      <= s_axis_tdata[71:40];
					res_last_q <= 1'b1;
					case (in_cmd)
						CMD_ADD: begin
							hole_q     <= ADDR_W'(count_q);
							res_kind_q <= full ? K_FULL : K_ADDED;
							res_id_q   <= id_to_out(in_id);
							res_exp_q  <= in_exp;
						end
						CMD_CANCEL: begin
							hole_q     <= '0;
							res_kind_q <= K_CANCEL_DONE;
							res_id_q   <= id_to_out(in_id);
							res_exp_q  <= '0;
						end
						CMD_POP: begin
							if (count_q == '0) begin
								res_kind_q <= K_POP_EMPTY;
								res_id_q   <= '0;
								res_exp_q  <= '0;
							end else begin
								res_kind_q <= K_POPPED;
								res_id_q   <= id_to_out(top_q.id);
								res_exp_q  <= top_q.expire;
							end
						end
						default: begin
							res_kind_q <= K_TICK_DONE;
							res_id_q   <= '0;
							res_exp_q  <= '0;
						end
					endcase
				end
			end
			ST_ADD_CMP: begin
				if (cmp_lt) begin
					hole_q <= parent;
				end
			end
			ST_CAN_CMP: begin
				hole_q <= hole_q + 1'b1;
			end
			ST_TICK_CHK: begin
				if (count_q == '0 || cmp_lt) begin
					res_kind_q <= K_TICK_DONE;
					res_id_q   <= '0;
					res_exp_q  <= '0;
					res_last_q <= 1'b1;
				end else begin
					res_kind_q <= K_FIRED;
					res_id_q   <= id_to_out(top_q.id);
					res_exp_q  <= top_q.expire;
					res_last_q <= 1'b0;
					fire_q     <= top_q.active;
				end
			end
			ST_REM_START: begin
				if (cmd_q == CMD_POP) begin
					fire_q <= 1'b1;
				end
			end
			ST_REM_HELD: begin
				held_q <= ram_rdata;
				hole_q <= '0;
			end
			ST_SINK_CHK: begin
				child_q <= ADDR_W'(child_w);
			end
			ST_SINK_L: begin
				sel_q      <= ram_rdata;
				sel_addr_q <= child_q;
			end
			ST_SINK_R: begin
				if (cmp_lt) begin
					sel_q      <= ram_rdata;
					sel_addr_q <= ADDR_W'(right_w);
				end
			end
			ST_SINK_DEC: begin
				if (cmp_lt) begin
					hole_q <= sel_addr_q;
				end
			end
			ST_OUT: begin
				if (load_out) begin
					m_kind_q  <= res_kind_q;
					m_last_q  <= res_last_q;
					m_id_q    <= res_id_q;
					m_exp_q   <= res_exp_q;
					m_cnt_q   <= 6'(count_q);
					m_top_q   <= (count_q == '0) ? 32'd0 : top_q.expire;
					m_empty_q <= (count_q == '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_empty_q, m_top_q, m_cnt_q, m_exp_q, m_id_q};
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;

	// The heap never holds more than its capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("heap count above capacity");

	// Every heap write lands inside the occupied region
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (IW'(ram_waddr) < IW'(count_q)))
		else $error("heap write beyond entry count");

	// Reads and writes in one cycle never hit the same entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("heap read and write collide");

	// An accepted add on a non-full heap grows it by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && in_cmd == CMD_ADD && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("add did not grow the heap");

	// Only fired results come without the last marker
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_last_q) |-> (m_kind_q == K_FIRED))
		else $error("non-final result is not a fired timer");

endmodule

FILE: bench/timer_queue_checker.sv
// Checker for the min-heap timer queue: predicts results per command and compares transfers.
module timer_queue_checker
	import mhtq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// tdata, lowest bit up: timer_id[7:0], delay[31:0], now[31:0]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: cmd[1:0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata, lowest bit up: result_id[7:0], result_expire[31:0],
	// pending_count[5:0], top_expire[31:0], heap_empty, pad
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	// tuser: kind[2:0]
	input  logic [OUT_USER_W-1:0] m_axis_tuser,
	input  logic                  m_axis_tlast,
	output int                    fail_count,
	output int                    outstanding
);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  rid;
		logic [31:0] rexp;
		logic [5:0]  cnt;
		logic [31:0] top;
		logic        empty;
		logic        last;
	} timer_result_t;

	slot_t          heap_mem [CAPACITY];
	int unsigned    heap_len;
	timer_result_t  queued_timer_results [$];
	timer_result_t  want_r;

	initial begin
		heap_len    = 0;
		fail_count  = 0;
		outstanding = 0;
	end

	// Snapshot the heap after the step and queue one expected result.
	task automatic post_result(input kind_t kind, input id_t id, input logic [31:0] expire,
			input logic last);
		timer_result_t r;
		r.kind  = kind;
		r.rid   = 8'(id);
		r.rexp  = expire;
		r.cnt   = 6'(heap_len);
		r.top   = (heap_len != 0) ? heap_mem[0].expire : 32'd0;
		r.empty = (heap_len == 0);
		r.last  = last;
		queued_timer_results.push_back(r);
	endtask

	// Move the last entry to the root and sink it; strict compares on both children.
	task automatic drop_root();
		int unsigned hole;
		int unsigned child;
		slot_t       held;
		heap_len--;
		heap_mem[0] = heap_mem[heap_len];
		if (heap_len != 0) begin
			hole = 0;
			held = heap_mem[0];
			while (hole * 2 + 1 < heap_len) begin
				child = hole * 2 + 1;
				if (child + 1 < heap_len && heap_mem[child + 1].expire < heap_mem[child].expire)
					child++;
				if (heap_mem[child].expire < held.expire) begin
					heap_mem[hole] = heap_mem[child];
					hole = child;
				end else begin
					break;
				end
			end
			heap_mem[hole] = held;
		end
	endtask

	task automatic predict_timer_cmd(input cmd_t cmd, input logic [7:0] raw_id,
			input logic [31:0] delay, input logic [31:0] now);
		id_t         id;
		logic [32:0] sum;
		logic [31:0] expiry;
		int unsigned hole;
		int unsigned parent;
		slot_t       taken;
		id = id_t'(raw_id);
		case (cmd)
			CMD_ADD: begin
				sum    = {1'b0, now} + {1'b0, delay};
				expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				if (heap_len >= CAPACITY) begin
					post_result(K_FULL, id, expiry, 1'b1);
				end else begin
					hole = heap_len;
					heap_len++;
					while (hole > 0) begin
						parent = (hole - 1) / 2;
						if (heap_mem[parent].expire <= expiry)
							break;
						heap_mem[hole] = heap_mem[parent];
						hole = parent;
					end
					heap_mem[hole].expire = expiry;
					heap_mem[hole].id     = id;
					heap_mem[hole].active = 1'b1;
					post_result(K_ADDED, id, expiry, 1'b1);
				end
			end
			CMD_CANCEL: begin
				for (int unsigned i = 0; i < heap_len; i++)
					if (heap_mem[i].id == id)
						heap_mem[i].active = 1'b0;
				post_result(K_CANCEL_DONE, id, 32'd0, 1'b1);
			end
			CMD_POP: begin
				if (heap_len == 0) begin
					post_result(K_POP_EMPTY, '0, 32'd0, 1'b1);
				end else begin
					taken = heap_mem[0];
					drop_root();
					post_result(K_POPPED, taken.id, taken.expire, 1'b1);
				end
			end
			default: begin
				// Expired cancelled entries leave silently.
				while (heap_len > 0 && heap_mem[0].expire <= now) begin
					taken = heap_mem[0];
					drop_root();
					if (taken.active)
						post_result(K_FIRED, taken.id, taken.expire, 1'b0);
				end
				post_result(K_TICK_DONE, '0, 32'd0, 1'b1);
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Inputs first, so a command's results are queued before any compare.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_timer_cmd(cmd_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[39:8],
					s_axis_tdata[71:40]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (queued_timer_results.size() == 0) begin
					$error("result transfer with no expected result, kind %0d", m_axis_tuser);
					fail_count++;
				end else begin
					want_r = queued_timer_results.pop_front();
					check_field("kind", want_r.kind, m_axis_tuser);
					check_field("result_id", want_r.rid, m_axis_tdata[7:0]);
					check_field("result_expire", want_r.rexp, m_axis_tdata[39:8]);
					check_field("pending_count", want_r.cnt, m_axis_tdata[45:40]);
					check_field("top_expire", want_r.top, m_axis_tdata[77:46]);
					check_field("heap_empty", want_r.empty, m_axis_tdata[78]);
					check_field("last", want_r.last, m_axis_tlast);
				end
			end
			outstanding = queued_timer_results.size();
		end
	end

endmodule

FILE: bench/tb_min_heap_timer_queue_core.sv
// Testbench top for the min-heap timer queue: clock, reset, command stimulus and verdict.
module tb_min_heap_timer_queue_core;
	import mhtq_pkg::*;

	// Random commands after the directed part.
	localparam int RANDOM_ITEMS = 130;
	// Start the long receiver hold-off while the first fill round is running.
	localparam int HOLD_AT      = 24;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 2_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	int fail_count;
	int outstanding;

	int items_sent = 0;
	int cycle_cnt  = 0;
	int sink_wait  = 0;
	bit sink_hold  = 1'b0;
	bit no_idle    = 1'b0;

	min_heap_timer_queue_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	timer_queue_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, a few long; none at all during a busy stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Small id pool so cancels hit live timers; the full range now and then.
	function automatic logic [7:0] pick_id();
		if ($urandom_range(0, 4) != 0)
			return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one command at a falling edge and hold it until the transfer happens.
	// Entered and left at a falling edge; valid stays high between back-to-back commands.
	task automatic issue_cmd(input cmd_t cmd, input logic [7:0] id, input logic [31:0] delay,
			input logic [31:0] now);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {now, delay, id};
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		// Flip between idling and busy stretches now and then.
		if (items_sent % 25 == 0)
			no_idle = ($urandom_range(0, 2) == 0);
		@(negedge clk);
	endtask

	// Receiver: random ready with gaps, forced low during the long hold-off.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold || sink_wait > 0) begin
				m_axis_tready <= 1'b0;
				if (!sink_hold)
					sink_wait--;
			end else begin
				m_axis_tready <= 1'b1;
				sink_wait = pick_gap();
			end
		end
	end

	// Hold off the receiver for a long stretch so the block backs up and stalls its input.
	initial begin
		while (items_sent < HOLD_AT)
			@(negedge clk);
		sink_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold = 1'b0;
	end

	// Watchdog on total run length.
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [31:0] base_now;
		int          n_add;
		int          n_tick;
		int          r;
		int          round;

		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_ADD;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty heap, extremes of id/delay/now, saturation, equal keys,
		// duplicate ids, lazy cancel, pop of a cancelled entry, tick draining.
		issue_cmd(CMD_POP, 8'h00, 32'd0, 32'd0);
		issue_cmd(CMD_TICK, 8'h00, 32'd0, 32'd0);
		issue_cmd(CMD_CANCEL, 8'h55, 32'd0, 32'd0);
		issue_cmd(CMD_ADD, 8'h00, 32'd0, 32'd0);
		issue_cmd(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_cmd(CMD_ADD, 8'h07, 32'd10, 32'd100);
		issue_cmd(CMD_ADD, 8'h08, 32'd10, 32'd100);
		issue_cmd(CMD_ADD, 8'h09, 32'd5, 32'd105);
		issue_cmd(CMD_ADD, 8'h07, 32'd2, 32'd100);
		issue_cmd(CMD_CANCEL, 8'h07, 32'd0, 32'd0);
		issue_cmd(CMD_ADD, 8'h03, 32'h8000_0000, 32'h7FFF_FFFF);
		issue_cmd(CMD_TICK, 8'h00, 32'd0, 32'd105);
		issue_cmd(CMD_POP, 8'h00, 32'd0, 32'd0);
		issue_cmd(CMD_TICK, 8'h00, 32'd0, 32'd110);
		issue_cmd(CMD_POP, 8'h00, 32'd0, 32'd0);
		issue_cmd(CMD_POP, 8'h00, 32'd0, 32'd0);
		issue_cmd(CMD_POP, 8'h00, 32'd0, 32'd0);
		issue_cmd(CMD_ADD, 8'hAA, 32'hFFFF_FFFF, 32'd0);
		issue_cmd(CMD_ADD, 8'h55, 32'h0000_0001, 32'hFFFF_FFFE);
		issue_cmd(CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// Random rounds: a burst of adds at the current time with a few cancels,
		// pops and wild adds mixed in, then ticks that advance time. The first
		// round adds past capacity to hit the full case.
		base_now = 32'd1000;
		round    = 0;
		while (items_sent < 20 + RANDOM_ITEMS) begin
			n_add = (round == 0) ? CAPACITY + 4 : $urandom_range(2, 18);
			for (int k = 0; k < n_add; k++) begin
				r = $urandom_range(0, 99);
				if (round == 0 || r >= 20)
					issue_cmd(CMD_ADD, pick_id(), $urandom_range(0, 60), base_now);
				else if (r < 8)
					issue_cmd(CMD_CANCEL, pick_id(), $urandom, $urandom);
				else if (r < 13)
					issue_cmd(CMD_POP, pick_id(), $urandom, $urandom);
				else
					issue_cmd(CMD_ADD, pick_id(), $urandom, $urandom);
			end
			n_tick = $urandom_range(1, 3);
			for (int k = 0; k < n_tick; k++) begin
				base_now = base_now + $urandom_range(0, 50);
				issue_cmd(CMD_TICK, pick_id(), $urandom, base_now);
			end
			// Sometimes drain everything, sometimes jump the clock anywhere.
			if ($urandom_range(0, 3) == 0)
				issue_cmd(CMD_TICK, pick_id(), $urandom, 32'hFFFF_FFFF);
			if ($urandom_range(0, 4) == 0)
				base_now = $urandom;
			round++;
		end
		s_axis_tvalid <= 1'b0;

		// Drain: every expected result in, then a few quiet cycles for strays.
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
